FILE: rtl/ptmd_pkg.sv
package ptmd_pkg;

  // Payload widths
  localparam int DIR_W   = 16;
  localparam int DELTA_W = 18;
  localparam int PPD_W   = 8;

  typedef logic signed [DIR_W-1:0]   dir_t;
  typedef logic signed [DELTA_W-1:0] delta_t;
  typedef logic [PPD_W-1:0]          ppd_t;

  localparam ppd_t PPD_RESET = 8'd40;

  // Components carry 8 guard bits into the CORDIC
  localparam int GUARD_SHIFT = 8;

  // CORDIC datapath width: 24-bit scaled operands, quarter-turn swap and gain ~1.65
  localparam int CORD_W = 27;

  // Square root: radicand is (x^2 + z^2) << 16, root fits 24 bits
  localparam int SUMSQ_W = 32;
  localparam int SQ_W    = 48;
  localparam int ROOT_W  = 24;
  localparam int SQ_STEPS = SQ_W / 2;

  // Degrees in one turn, used for the pixel scale
  localparam int DEG_PER_TURN = 360;

  // Step angles atan(2^-i) in units of 2^-32 turn
  localparam int STEP_TABLE_LEN = 24;
  localparam int TIDX_W = 5;
  localparam logic [31:0] STEP_ANGLE32 [STEP_TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

endpackage

FILE: rtl/pose_to_mouse_delta_unit.sv
// Each item runs two squarings, the 24 square-root steps and two CORDIC passes of one
//   iteration per cycle, then two pixel-scale passes; no new item is taken until the result
//   is loaded into the output register, which waits while a previous result is not yet taken.
// An item with tracker_ready low is taken without leaving idle and gives no result; the next beat
//   is taken while a finished result still waits in the output register.
// Reset (synchronous, active high): idle, no result pending, scale 40, home and last positions cleared.
module pose_to_mouse_delta_unit #(
  parameter int CORDIC_ITERATIONS = 16,
  parameter int ANGLE_BITS        = 16
) (
  input  logic              clk,
  input  logic              rst,
  // configuration write
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  ptmd_pkg::ppd_t    cfg_data,
  // input item
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              tracker_ready,
  input  logic              enable_pressed,
  input  ptmd_pkg::dir_t    dir_x,
  input  ptmd_pkg::dir_t    dir_y,
  input  ptmd_pkg::dir_t    dir_z,
  // result item
  output logic              out_valid,
  input  logic              out_ready,
  output ptmd_pkg::delta_t  delta_x,
  output ptmd_pkg::delta_t  delta_y
);
  import ptmd_pkg::*;

  localparam int AB = ANGLE_BITS;
  localparam int MA = (AB + 1 > DIR_W + 1) ? AB + 1 : DIR_W + 1;
  localparam int MB = DIR_W + 1;
  localparam int P2_W = AB + 17;
  localparam int PIX_W = DELTA_W - 1;
  localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);
  localparam logic [TIDX_W-1:0] LAST_ITER = TIDX_W'(CORDIC_ITERATIONS - 1);
  localparam logic [TIDX_W-1:0] LAST_SQ = TIDX_W'(SQ_STEPS - 1);

  // Sequencer codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQX   = 4'd1;
  localparam logic [3:0] S_SQZ   = 4'd2;
  localparam logic [3:0] S_SQRT  = 4'd3;
  localparam logic [3:0] S_CINIT = 4'd4;
  localparam logic [3:0] S_CORD  = 4'd5;
  localparam logic [3:0] S_PX1   = 4'd6;
  localparam logic [3:0] S_PX2   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state;

  // Configuration and persistent state
  ppd_t          ppd;
  logic [AB-1:0] home_az;
  logic [AB-1:0] home_el;
  delta_t        last_x;
  delta_t        last_y;

  // Captured item
  logic en_q;
  dir_t x_q;
  dir_t y_q;
  dir_t z_q;

  // Working registers
  logic                     pass;
  logic [SUMSQ_W-1:0]       sumsq;
  logic [SQ_W-1:0]          rem_v;
  logic [SQ_W-1:0]          root;
  logic [SQ_W-1:0]          sbit;
  logic [TIDX_W-1:0]        scnt;
  logic signed [CORD_W-1:0] cx;
  logic signed [CORD_W-1:0] cy;
  logic [AB-1:0]            cz;
  logic                     zflag;
  logic [TIDX_W-1:0]        cnt;
  logic [AB-1:0]            ang_az;
  logic [AB-1:0]            ang_el;
  logic [AB+7:0]            prod1;
  logic                     neg;
  delta_t                   nx;
  delta_t                   ny;

  // Component magnitudes for squaring
  logic signed [DIR_W:0] xs, zs;
  logic [DIR_W:0]        mag_x, mag_z;

  assign xs = {x_q[DIR_W-1], x_q};
  assign zs = {z_q[DIR_W-1], z_q};
  assign mag_x = xs[DIR_W] ? (DIR_W+1)'(-xs) : (DIR_W+1)'(xs);
  assign mag_z = zs[DIR_W] ? (DIR_W+1)'(-zs) : (DIR_W+1)'(zs);

  // Angle offsets from home
  logic signed [AB-1:0] az_off;
  logic signed [AB:0]   el_off;
  logic signed [AB:0]   off_s;
  logic [AB:0]          off_abs;

  assign az_off = $signed(ang_az - home_az);
  assign el_off = $signed({ang_el[AB-1], ang_el}) - $signed({home_el[AB-1], home_el});
  assign off_s = pass ? el_off : {az_off[AB-1], az_off};
  assign off_abs = off_s[AB] ? (AB+1)'(-off_s) : (AB+1)'(off_s);

  // Shared multiplier: squares of x and z, then angle offset times scale
  logic [MA-1:0]    mul_a;
  logic [MB-1:0]    mul_b;
  logic [MA+MB-1:0] mul_p;

  always_comb begin
    case (state)
      S_SQX: begin
        mul_a = MA'(mag_x);
        mul_b = mag_x;
      end
      S_SQZ: begin
        mul_a = MA'(mag_z);
        mul_b = mag_z;
      end
      default: begin
        mul_a = MA'(off_abs);
        mul_b = MB'(ppd);
      end
    endcase
  end

  assign mul_p = (MA+MB)'(mul_a) * (MA+MB)'(mul_b);

  // Square-root trial value
  logic [SQ_W-1:0]    trial;
  logic [SUMSQ_W-1:0] sumsq_full;

  assign trial = root + sbit;
  assign sumsq_full = sumsq + SUMSQ_W'(mul_p);

  // CORDIC operands and pre-rotation
  logic signed [CORD_W-1:0] ox, oy;

  assign ox = pass ? $signed({{(CORD_W-ROOT_W){1'b0}}, root[ROOT_W-1:0]})
                   : ($signed({{(CORD_W-DIR_W){x_q[DIR_W-1]}}, x_q}) <<< GUARD_SHIFT);
  assign oy = pass ? ($signed({{(CORD_W-DIR_W){y_q[DIR_W-1]}}, y_q}) <<< GUARD_SHIFT)
                   : ($signed({{(CORD_W-DIR_W){z_q[DIR_W-1]}}, z_q}) <<< GUARD_SHIFT);

  // CORDIC iteration: shared shifter and step-angle lookup
  logic signed [CORD_W-1:0] shx, shy;
  logic [32:0]              st_sum;
  logic [AB-1:0]            step;
  logic [AB-1:0]            cz_next;
  logic                     rot_neg;

  assign shx = cy >>> cnt;
  assign shy = cx >>> cnt;
  assign st_sum = {1'b0, STEP_ANGLE32[cnt]} + (33'd1 << (31 - AB));
  assign step = st_sum[32-AB +: AB];
  assign rot_neg = (cy > 0);
  assign cz_next = rot_neg ? cz + step : cz - step;

  // Pixel scale: (|offset| * ppd) * 360 >> ANGLE_BITS
  logic [P2_W-1:0]  p2;
  logic [PIX_W-1:0] pix;
  delta_t           pos;

  assign p2 = P2_W'(P2_W'(prod1) * P2_W'(DEG_PER_TURN));
  assign pix = p2[AB +: PIX_W];
  assign pos = $signed({1'b0, pix});

  assign in_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      ppd <= PPD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ppd <= cfg_data;
    end
  end

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      home_az   <= '0;
      home_el   <= '0;
      last_x    <= '0;
      last_y    <= '0;
      pass      <= 1'b0;
    end else begin
      // S_DONE loads the next result itself
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && tracker_ready) begin
            state <= S_SQX;
          end
        end
        S_SQX: begin
          state <= S_SQZ;
        end
        S_SQZ: begin
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (scnt == LAST_SQ) begin
            pass  <= 1'b0;
            state <= S_CINIT;
          end
        end
        S_CINIT: begin
          state <= S_CORD;
        end
        S_CORD: begin
          if (cnt == LAST_ITER) begin
            if (!pass) begin
              pass  <= 1'b1;
              state <= S_CINIT;
            end else begin
              // latch home while the button is up
              if (!en_q) begin
                home_az <= ang_az;
                home_el <= zflag ? '0 : cz_next;
              end
              pass  <= 1'b0;
              state <= S_PX1;
            end
          end
        end
        S_PX1: begin
          state <= S_PX2;
        end
        S_PX2: begin
          if (!pass) begin
            pass  <= 1'b1;
            state <= S_PX1;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            last_x    <= nx;
            last_y    <= ny;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid && tracker_ready) begin
          en_q <= enable_pressed;
          x_q  <= dir_x;
          y_q  <= dir_y;
          z_q  <= dir_z;
        end
      end
      S_SQX: begin
        sumsq <= SUMSQ_W'(mul_p);
      end
      S_SQZ: begin
        rem_v <= {sumsq_full, 16'd0};
        root  <= '0;
        sbit  <= SQ_W'(1) << (SQ_W - 2);
        scnt  <= '0;
      end
      S_SQRT: begin
        // one digit-pair of the root per cycle
        if (rem_v >= trial) begin
          rem_v <= rem_v - trial;
          root  <= (root >> 1) + sbit;
        end else begin
          root <= root >> 1;
        end
        sbit <= sbit >> 2;
        scnt <= scnt + 1'b1;
      end
      S_CINIT: begin
        zflag <= (ox == 0) && (oy == 0);
        cnt   <= '0;
        if (ox < 0) begin
          if (oy >= 0) begin
            cx <= oy;
            cy <= -ox;
            cz <= QUARTER;
          end else begin
            cx <= -oy;
            cy <= ox;
            cz <= -QUARTER;
          end
        end else begin
          cx <= ox;
          cy <= oy;
          cz <= '0;
        end
      end
      S_CORD: begin
        if (rot_neg) begin
          cx <= cx + shx;
          cy <= cy - shy;
        end else begin
          cx <= cx - shx;
          cy <= cy + shy;
        end
        cz  <= cz_next;
        cnt <= cnt + 1'b1;
        if (cnt == LAST_ITER) begin
          if (!pass) begin
            ang_az <= zflag ? '0 : cz_next;
          end else begin
            ang_el <= zflag ? '0 : cz_next;
          end
        end
      end
      S_PX1: begin
        prod1 <= (AB+8)'(mul_p);
        neg   <= off_s[AB];
      end
      S_PX2: begin
        // elevation up maps to negative y
        if (!pass) begin
          nx <= neg ? -pos : pos;
        end else begin
          ny <= neg ? pos : -pos;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          delta_x <= en_q ? nx - last_x : '0;
          delta_y <= en_q ? ny - last_y : '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Checks
  a_not_ready_skip: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !tracker_ready) |=> in_ready)
    else $error("item without tracker_ready did not return to idle");

  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && tracker_ready) |=> !in_ready)
    else $error("sequencer did not start on a ready item");

  a_iter_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CORD) |-> (cnt <= LAST_ITER))
    else $error("CORDIC iteration count out of range");

  a_sqrt_bit: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQRT) |-> $onehot(sbit))
    else $error("square-root trial bit lost");

endmodule
